// File: rtl/core/tat_pkg.sv
// package for the ttl aging address table
// types, codes and constants shared by the cell and the top level; no dependencies
package tat_pkg;

  localparam int unsigned EntriesDefault = 32;
  localparam int unsigned ExpW = 33;
  localparam int unsigned CountW = 6;

  localparam logic       CmdAdd   = 1'b0;
  localparam logic       CmdSweep = 1'b1;

  localparam logic [1:0] KindAdd     = 2'd0;
  localparam logic [1:0] KindRemoved = 2'd1;
  localparam logic [1:0] KindDone    = 2'd2;

  localparam logic [1:0] StRenewed  = 2'd0;
  localparam logic [1:0] StInserted = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  typedef struct packed {
    logic        command;
    logic [7:0]  table_id;
    logic        family;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [31:0] ttl;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  add_status;
    logic [7:0]  removed_table;
    logic        removed_family;
    logic [63:0] removed_addr_hi;
    logic [63:0] removed_addr_lo;
    logic [5:0]  removed_count;
    logic        last;
  } rsp_t;

  // one stored entry, also the word shifted along the sweep chain
  typedef struct packed {
    logic [7:0]      tbl;
    logic            fam;
    logic [63:0]     hi;
    logic [63:0]     lo;
    logic [ExpW-1:0] exp;
  } entry_t;

  // per-cell controls from the sequencer
  typedef struct packed {
    logic            renew;    // raise expiry if this cell hits
    logic            insert;   // write the request into this cell
    logic            rotate;   // shift entries one cell down the chain
    logic [31:0]     now;
  } cell_ctl_t;

endpackage

// File: rtl/core/tat_cell.sv
// one slot of the table: valid bit, entry and local match compare
// depends on tat_pkg
module tat_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tat_pkg::cell_ctl_t ctl_i,
  input  tat_pkg::entry_t  key_i,
  input  tat_pkg::entry_t  nb_entry_i,
  input  logic             nb_valid_i,
  input  logic             clear_i,
  output tat_pkg::entry_t  entry_o,
  output logic             valid_o,
  output logic             hit_o,
  output logic             expired_o
);
  import tat_pkg::*;

  entry_t ent_q, ent_d;
  logic   val_q, val_d;

  always_comb begin
    hit_o = val_q && ent_q.tbl == key_i.tbl && ent_q.fam == key_i.fam &&
            ent_q.lo[31:0] == key_i.lo[31:0] &&
            (!key_i.fam || (ent_q.hi == key_i.hi && ent_q.lo[63:32] == key_i.lo[63:32]));
    expired_o = val_q && ent_q.exp <= {1'b0, ctl_i.now};
  end

  always_comb begin
    ent_d = ent_q;
    val_d = val_q;
    if (ctl_i.rotate) begin
      ent_d = nb_entry_i;
      val_d = nb_valid_i;
    end else if (ctl_i.insert) begin
      ent_d = key_i;
      val_d = 1'b1;
    end else if (ctl_i.renew && hit_o && key_i.exp > ent_q.exp) begin
      ent_d.exp = key_i.exp;
    end
    if (clear_i) val_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) val_q <= 1'b0;
    else val_q <= val_d;
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign entry_o = ent_q;
  assign valid_o = val_q;
endmodule

// File: rtl/core/ttl_aging_address_table_unit.sv
// top level of the ttl aging address table: chain of slot cells plus sequencer
// depends on tat_pkg and tat_cell
//
// usage: drive req_i and pulse start_i while busy_o is low. each result
// appears on rsp_o for one cycle with rsp_valid_o high; the receiver cannot
// stall, so results are simply presented once.
// an add registers the request, then all cells compare in parallel and
// one status result follows (busy for one cycle).
// a sweep rotates the chain of ENTRIES cells once: cell 0 is examined each
// cycle and wraps to the top, so slots are seen in ascending order; each
// expired slot gives a removed result as it passes cell 0, then a done
// result with the count and last set.
// the slowest path is the cell compare plus the lowest-free-slot priority.
// reset clears all valid bits at once; entry contents are not reset.
module ttl_aging_address_table_unit #(
  parameter int unsigned ENTRIES = tat_pkg::EntriesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  tat_pkg::req_t  req_i,
  output logic           busy_o,
  output logic           rsp_valid_o,
  output tat_pkg::rsp_t  rsp_o
);
  import tat_pkg::*;

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_SWP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]      state_q, state_d;
  req_t            req_q;
  entry_t          key;
  logic [IdxW-1:0] step_q, step_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  rsp_t            rsp_q, rsp_d;
  logic            rv_q, rv_d;

  entry_t            ent   [ENTRIES];
  logic [ENTRIES-1:0] val, hit, expd, ins, clr;
  cell_ctl_t         ctl;

  always_comb begin
    key.tbl = req_q.table_id;
    key.fam = req_q.family;
    key.hi  = req_q.family ? req_q.addr_hi : 64'd0;
    key.lo  = req_q.family ? req_q.addr_lo : {32'd0, req_q.addr_lo[31:0]};
    key.exp = {1'b0, req_q.ttl} + {1'b0, req_q.now};
  end

  // lowest free slot, one-hot
  always_comb begin
    ins = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!val[i] && ins == '0) ins[i] = 1'b1;
    end
  end

  wire any_hit = |hit;
  wire do_add  = state_q == S_ADD;
  wire do_rot  = state_q == S_SWP;

  always_comb begin
    ctl.renew  = do_add;
    ctl.insert = 1'b0;
    ctl.rotate = do_rot;
    ctl.now    = req_q.now;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    cell_ctl_t c;
    always_comb begin
      c = ctl;
      c.insert = do_add && !any_hit && ins[g];
    end
    // entry leaving cell 0 is dropped when expired
    assign clr[g] = do_rot && (g == ENTRIES - 1) && expd[0];
    tat_cell u_cell (
      .clk_i, .rst_ni, .ctl_i(c), .key_i(key),
      .nb_entry_i(ent[(g + 1) % ENTRIES]),
      .nb_valid_i(val[(g + 1) % ENTRIES]),
      .clear_i(clr[g]),
      .entry_o(ent[g]), .valid_o(val[g]), .hit_o(hit[g]), .expired_o(expd[g])
    );
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    rsp_d   = '0;
    rv_d    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          step_d  = '0;
          cnt_d   = '0;
          state_d = (req_i.command == CmdSweep) ? S_SWP : S_ADD;
        end
      end
      S_ADD: begin
        rv_d = 1'b1;
        rsp_d.kind = KindAdd;
        rsp_d.last = 1'b1;
        if (any_hit) rsp_d.add_status = StRenewed;
        else if (ins != '0) rsp_d.add_status = StInserted;
        else rsp_d.add_status = StFull;
        state_d = S_IDLE;
      end
      S_SWP: begin
        if (expd[0]) begin
          rv_d = 1'b1;
          rsp_d.kind            = KindRemoved;
          rsp_d.removed_table   = ent[0].tbl;
          rsp_d.removed_family  = ent[0].fam;
          rsp_d.removed_addr_hi = ent[0].hi;
          rsp_d.removed_addr_lo = ent[0].lo;
          cnt_d = cnt_q + 1'b1;
        end
        if (step_q == IdxW'(ENTRIES - 1)) state_d = S_DONE;
        else step_d = step_q + 1'b1;
      end
      S_DONE: begin
        rv_d = 1'b1;
        rsp_d.kind          = KindDone;
        rsp_d.removed_count = CountW'(cnt_q);
        rsp_d.last          = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (state_q == S_IDLE && start_i) req_q <= req_i;
  end

  assign busy_o      = state_q != S_IDLE;
  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;
endmodule
